FILE: rtl/suis_pkg.sv
// ----------------------------------------------------------------------------
// suis_pkg
// Shared command codes, field widths and cell control type for the sorted
// unique id set.
// ----------------------------------------------------------------------------
package suis_pkg;

	localparam int CMD_W = 2;
	localparam int LEN_W = 5;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_MATCH = 2'd3;

	// Control broadcast to every cell of the row
	typedef struct packed {
		logic ins;   // insert the broadcast id at its sorted place
		logic load;  // write the broadcast id (only the first cell sees this)
	} cell_ctrl_t;

endpackage

FILE: rtl/suis_cell.sv
// ----------------------------------------------------------------------------
// suis_cell
// One entry of the sorted list: compares the broadcast id with its own entry
// and, on a load, takes the id; on an insert, keeps its entry, takes the new id
// or takes the entry of its left neighbour.
// ----------------------------------------------------------------------------
module suis_cell #(
	parameter int ID_BITS = 32
) (
	input  logic                clk,
	input  suis_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  logic [ID_BITS-1:0]  id,
	input  logic [ID_BITS-1:0]  left_data,
	input  logic                left_gt,
	output logic [ID_BITS-1:0]  data,
	output logic                gt,
	output logic                eq
);

	logic [ID_BITS-1:0] data_q;

	assign data = data_q;
	assign gt   = occ && (id > data_q);
	assign eq   = occ && (id == data_q);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= id;
		end else if (ctrl.ins && !gt) begin
			// the first cell not below the new id takes it, the rest shift right
			data_q <= left_gt ? id : left_data;
		end
	end

endmodule

FILE: rtl/sorted_unique_id_set.sv
// ----------------------------------------------------------------------------
// sorted_unique_id_set
// Bounded ascending list of ids without duplicates, held in a row of
// compare-and-shift cells, with clear, set, add and streamed match commands.
// ----------------------------------------------------------------------------
// Results: done is registered and rises in the cycle after an accepted item that gives a result;
// a match item gives one only at the end of its sequence. Throughput: one item per cycle while
// busy is low; every cell compares the broadcast id in parallel and shifts into its neighbour in the same cycle.
// Reset: list empty, accumulate flag set, match sequence idle; busy is high
// for the first cycle after reset. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module sorted_unique_id_set #(
	parameter int LIST_DEPTH = 16,
	parameter int ID_BITS    = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [suis_pkg::CMD_W-1:0]         command,
	input  logic [ID_BITS-1:0]                 id,
	input  logic [suis_pkg::LEN_W-1:0]         other_length,
	output logic                               done,
	output logic                               is_verdict,
	output logic                               matched,
	output logic [$clog2(LIST_DEPTH+1)-1:0]    entry_count,
	output logic                               accumulates,
	output logic                               overflow
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int LEN_W = suis_pkg::LEN_W;
	localparam int CW    = CNT_W + LEN_W + 1;

	logic [CNT_W-1:0] count_q;
	logic             acc_q;
	logic [LEN_W-1:0] pos_q;
	logic             fail_q;
	logic             busy_q;
	logic             done_q;
	logic             verdict_q;
	logic             matched_q;
	logic             ovf_q;

	logic [ID_BITS-1:0]  data_arr [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] gt_vec;
	logic [LIST_DEPTH-1:0] eq_vec;
	logic [LIST_DEPTH-1:0] sel_vec;
	suis_pkg::cell_ctrl_t  ctrl;
	suis_pkg::cell_ctrl_t  ctrl_first;

	logic           accept;
	logic           dup;
	logic           full;
	logic           hit;
	logic           fail_now;
	logic           last;
	logic           len_zero;
	logic [LEN_W:0] pos_inc;
	logic           list_eq;

	assign accept   = start && !busy_q;
	assign dup      = |eq_vec;
	assign full     = (count_q == CNT_W'(LIST_DEPTH));
	assign hit      = |(sel_vec & eq_vec);
	assign fail_now = fail_q || !hit;
	assign pos_inc  = {1'b0, pos_q} + (LEN_W+1)'(1);
	assign last     = (pos_inc >= {1'b0, other_length});
	assign len_zero = (other_length == '0);
	assign list_eq  = len_zero ? (count_q == '0)
	                           : (!fail_now && (CW'(pos_inc) == CW'(count_q)));

	assign ctrl.ins        = accept && (command == suis_pkg::CMD_ADD) && !dup && !full;
	assign ctrl.load       = 1'b0;
	assign ctrl_first.ins  = ctrl.ins;
	assign ctrl_first.load = accept && (command == suis_pkg::CMD_SET);

	generate
		for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
			logic occ;
			assign occ        = (CNT_W'(i) < count_q);
			assign sel_vec[i] = (CW'(pos_q) == CW'(i));
			if (i == 0) begin : g_first
				suis_cell #(.ID_BITS(ID_BITS)) u_cell (
					.clk       (clk),
					.ctrl      (ctrl_first),
					.occ       (occ),
					.id        (id),
					.left_data (id),
					.left_gt   (1'b1),
					.data      (data_arr[i]),
					.gt        (gt_vec[i]),
					.eq        (eq_vec[i])
				);
			end else begin : g_rest
				suis_cell #(.ID_BITS(ID_BITS)) u_cell (
					.clk       (clk),
					.ctrl      (ctrl),
					.occ       (occ),
					.id        (id),
					.left_data (data_arr[i-1]),
					.left_gt   (gt_vec[i-1]),
					.data      (data_arr[i]),
					.gt        (gt_vec[i]),
					.eq        (eq_vec[i])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			acc_q     <= 1'b1;
			pos_q     <= '0;
			fail_q    <= 1'b0;
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
			verdict_q <= 1'b0;
			matched_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			verdict_q <= 1'b0;
			matched_q <= 1'b0;
			ovf_q     <= 1'b0;
			if (accept) begin
				case (command)
					suis_pkg::CMD_CLEAR: begin
						count_q <= '0;
						acc_q   <= 1'b0;
						pos_q   <= '0;
						fail_q  <= 1'b0;
						done_q  <= 1'b1;
					end
					suis_pkg::CMD_SET: begin
						count_q <= CNT_W'(1);
						acc_q   <= 1'b0;
						pos_q   <= '0;
						fail_q  <= 1'b0;
						done_q  <= 1'b1;
					end
					suis_pkg::CMD_ADD: begin
						if (ctrl.ins) begin
							count_q <= count_q + CNT_W'(1);
						end
						ovf_q  <= !dup && full;
						pos_q  <= '0;
						fail_q <= 1'b0;
						done_q <= 1'b1;
					end
					suis_pkg::CMD_MATCH: begin
						if (len_zero || last) begin
							// end of sequence: give the verdict and rearm
							pos_q     <= '0;
							fail_q    <= 1'b0;
							done_q    <= 1'b1;
							verdict_q <= 1'b1;
							matched_q <= list_eq;
						end else begin
							pos_q  <= pos_inc[LEN_W-1:0];
							fail_q <= fail_now;
						end
					end
					default: begin
						done_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign is_verdict  = verdict_q;
	assign matched     = matched_q;
	assign entry_count = count_q;
	assign accumulates = acc_q;
	assign overflow    = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_DEPTH))
		else $error("entry count beyond list depth");

	a_ovf_status: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (done_q && !verdict_q))
		else $error("overflow outside a status result");

	a_match_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		matched_q |-> (done_q && verdict_q))
		else $error("matched outside a verdict");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == suis_pkg::CMD_ADD) && full && !dup)
		|=> (done_q && ovf_q && ($past(count_q) == count_q)))
		else $error("add to full list not dropped");

endmodule

FILE: bench/sorted_unique_id_set_checker.sv
// ----------------------------------------------------------------------------
// sorted_unique_id_set_checker
// Watches the command and result channels of the sorted unique id set, keeps
// its own copy of the stored list and match state, predicts the status or
// verdict for each accepted command that gives a result and compares every result field with it.
// ----------------------------------------------------------------------------
module sorted_unique_id_set_checker #(
	parameter int LIST_DEPTH = 16,
	parameter int ID_BITS    = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [suis_pkg::CMD_W-1:0]         command,
	input  logic [ID_BITS-1:0]                 id,
	input  logic [suis_pkg::LEN_W-1:0]         other_length,
	input  logic                               done,
	input  logic                               is_verdict,
	input  logic                               matched,
	input  logic [$clog2(LIST_DEPTH+1)-1:0]    entry_count,
	input  logic                               accumulates,
	input  logic                               overflow,
	output int                                 fails,
	output int                                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W = $clog2(LIST_DEPTH+1);
	localparam int CMD_W = suis_pkg::CMD_W;
	localparam int LEN_W = suis_pkg::LEN_W;

	typedef struct packed {
		logic             is_verdict;
		logic             matched;
		logic [CNT_W-1:0] entry_count;
		logic             accumulates;
		logic             overflow;
	} status_t;

	logic [ID_BITS-1:0] set_ids [LIST_DEPTH];
	int                 set_size   = 0;
	logic               accum_flag = 1'b1;
	int                 seq_pos    = 0;
	logic               seq_bad    = 1'b0;
	status_t            awaited [$];

	initial begin
		fails       = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string msg);
		if (fails < 100)
			$display("%0t ns: mismatch: %s", $time, msg);
		fails++;
	endtask

	task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [ID_BITS-1:0] val,
			input logic [LEN_W-1:0] len);
		status_t res;
		int      pos;
		res = '0;
		if (cmd == suis_pkg::CMD_MATCH) begin
			if (len != 0) begin
				if (seq_pos >= set_size)
					seq_bad = 1'b1;
				else if (set_ids[seq_pos] != val)
					seq_bad = 1'b1;
				// hold the sequence open until its last element
				if (seq_pos + 1 < len) begin
					seq_pos++;
					return;
				end
			end
			res.is_verdict = 1'b1;
			res.matched    = (len == 0) ? (set_size == 0) : (!seq_bad && seq_pos + 1 == set_size);
		end else begin
			case (cmd)
			suis_pkg::CMD_CLEAR: begin
				set_size   = 0;
				accum_flag = 1'b0;
			end
			suis_pkg::CMD_SET: begin
				set_ids[0] = val;
				set_size   = 1;
				accum_flag = 1'b0;
			end
			default: begin
				pos = 0;
				while (pos < set_size && val > set_ids[pos])
					pos++;
				if (pos < set_size && val == set_ids[pos]) begin
					// already present: nothing changes, even when full
				end else if (set_size >= LIST_DEPTH) begin
					res.overflow = 1'b1;
				end else begin
					for (int k = set_size; k > pos; k--)
						set_ids[k] = set_ids[k-1];
					set_ids[pos] = val;
					set_size++;
				end
			end
			endcase
		end
		// any status command abandons a partial match
		seq_pos = 0;
		seq_bad = 1'b0;
		res.entry_count = CNT_W'(set_size);
		res.accumulates = accum_flag;
		awaited.push_back(res);
	endtask

	task automatic check_result();
		status_t want;
		if (awaited.size() == 0) begin
			report_mismatch("result with nothing awaited");
			return;
		end
		want = awaited.pop_front();
		if (is_verdict !== want.is_verdict)
			report_mismatch($sformatf("is_verdict got %b want %b", is_verdict, want.is_verdict));
		if (matched !== want.matched)
			report_mismatch($sformatf("matched got %b want %b", matched, want.matched));
		if (entry_count !== want.entry_count)
			report_mismatch($sformatf("entry_count got %0d want %0d", entry_count,
				want.entry_count));
		if (accumulates !== want.accumulates)
			report_mismatch($sformatf("accumulates got %b want %b", accumulates,
				want.accumulates));
		if (overflow !== want.overflow)
			report_mismatch($sformatf("overflow got %b want %b", overflow, want.overflow));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			set_size   = 0;
			accum_flag = 1'b1;
			seq_pos    = 0;
			seq_bad    = 1'b0;
			awaited.delete();
		end else begin
			if (done)
				check_result();
			if (start && !busy)
				apply_command(command, id, other_length);
		end
		outstanding = awaited.size();
	end

endmodule

FILE: bench/sorted_unique_id_set_tb.sv
// ----------------------------------------------------------------------------
// sorted_unique_id_set_tb
// Drives clear, set, add and streamed match commands into the sorted unique
// id set in random bursts: a directed opening, a fill to overflow, then random
// list building, exact and broken match sequences and noise.
// ----------------------------------------------------------------------------
module sorted_unique_id_set_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 16;
	localparam int ID_BITS    = 32;
	localparam int ITEMS      = 1750;
	localparam int CMD_W      = suis_pkg::CMD_W;
	localparam int LEN_W      = suis_pkg::LEN_W;

	typedef logic [ID_BITS-1:0] id_q_t [$];

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             start        = 1'b0;
	logic [CMD_W-1:0]                 command      = suis_pkg::CMD_CLEAR;
	logic [ID_BITS-1:0]               id           = '0;
	logic [LEN_W-1:0]                 other_length = '0;
	logic                             busy;
	logic                             done;
	logic                             is_verdict;
	logic                             matched;
	logic [$clog2(LIST_DEPTH+1)-1:0]  entry_count;
	logic                             accumulates;
	logic                             overflow;
	int                               fails;
	int                               outstanding;

	// stimulus-side view of the stored list, used to build match sequences and to pick stored ids
	id_q_t stored;
	int    sent       = 0;
	int    burst_left = 0;

	always #1 clk = ~clk;

	sorted_unique_id_set #(
		.LIST_DEPTH(LIST_DEPTH),
		.ID_BITS   (ID_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.id          (id),
		.other_length(other_length),
		.done        (done),
		.is_verdict  (is_verdict),
		.matched     (matched),
		.entry_count (entry_count),
		.accumulates (accumulates),
		.overflow    (overflow)
	);

	sorted_unique_id_set_checker #(
		.LIST_DEPTH(LIST_DEPTH),
		.ID_BITS   (ID_BITS)
	) id_set_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.id          (id),
		.other_length(other_length),
		.done        (done),
		.is_verdict  (is_verdict),
		.matched     (matched),
		.entry_count (entry_count),
		.accumulates (accumulates),
		.overflow    (overflow),
		.fails       (fails),
		.outstanding (outstanding)
	);

	function automatic logic [ID_BITS-1:0] pick_id();
		case ($urandom_range(0, 7))
		0: return $urandom_range(0, 1) ? '1 : '0;
		1, 2, 3: return $urandom_range(0, 40);
		4: return (stored.size() > 0) ? stored[$urandom_range(0, stored.size() - 1)] : $urandom;
		default: return $urandom;
		endcase
	endfunction

	// one transfer, then possibly close the burst with a gap
	task automatic send(input logic [CMD_W-1:0] cmd, input logic [ID_BITS-1:0] val,
			input logic [LEN_W-1:0] len);
		int pos;
		start        <= 1'b1;
		command      <= cmd;
		id           <= val;
		other_length <= len;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		case (cmd)
		suis_pkg::CMD_CLEAR: stored.delete();
		suis_pkg::CMD_SET: begin
			stored.delete();
			stored.push_back(val);
		end
		suis_pkg::CMD_ADD: begin
			pos = 0;
			while (pos < stored.size() && val > stored[pos])
				pos++;
			if (!(pos < stored.size() && val == stored[pos]) && stored.size() < LIST_DEPTH)
				stored.insert(pos, val);
		end
		default: ;
		endcase
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
		end
	endtask

	task automatic stream_match(input id_q_t elems, input int len);
		if (len == 0)
			send(suis_pkg::CMD_MATCH, $urandom, '0);
		else
			foreach (elems[k])
				send(suis_pkg::CMD_MATCH, elems[k], LEN_W'(len));
	endtask

	initial begin
		id_q_t elems;
		int    cut;
		int    k;

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty against empty straight after reset; the id is ignored
		send(suis_pkg::CMD_MATCH, '1, 5'd0);
		send(suis_pkg::CMD_ADD, '1, 5'd0);
		send(suis_pkg::CMD_ADD, '0, 5'd0);
		send(suis_pkg::CMD_ADD, '0, 5'd0);
		send(suis_pkg::CMD_ADD, 32'h8000_0000, 5'd16);
		stream_match(stored, stored.size());
		send(suis_pkg::CMD_MATCH, 32'h8000_0000, 5'd0);
		send(suis_pkg::CMD_SET, 32'd5, 5'd16);
		// compared list runs past the stored one
		send(suis_pkg::CMD_MATCH, 32'd5, 5'd2);
		send(suis_pkg::CMD_MATCH, 32'd6, 5'd2);
		// length shrinks mid-sequence
		send(suis_pkg::CMD_MATCH, 32'd5, 5'd3);
		send(suis_pkg::CMD_MATCH, 32'd9, 5'd1);
		// add abandons the partial match
		send(suis_pkg::CMD_MATCH, 32'd5, 5'd2);
		send(suis_pkg::CMD_ADD, 32'd7, 5'd0);
		send(suis_pkg::CMD_MATCH, 32'd5, 5'd1);
		send(suis_pkg::CMD_SET, 32'd3, 5'd0);
		send(suis_pkg::CMD_MATCH, 32'd4, 5'd1);
		send(suis_pkg::CMD_CLEAR, '1, 5'd16);

		// fill up, overflow with a new id, then a duplicate while full
		for (k = 1; k <= LIST_DEPTH; k++)
			send(suis_pkg::CMD_ADD, ID_BITS'(2 * k), 5'(k));
		send(suis_pkg::CMD_ADD, 32'd33, 5'd0);
		send(suis_pkg::CMD_ADD, 32'd2, 5'd0);
		stream_match(stored, stored.size());

		while (sent < ITEMS) begin
			elems = stored;
			case ($urandom_range(0, 9))
			0, 1: begin
				if ($urandom_range(0, 1))
					send(suis_pkg::CMD_CLEAR, $urandom, LEN_W'($urandom_range(0, 16)));
				else
					send(suis_pkg::CMD_SET, pick_id(), LEN_W'($urandom_range(0, 16)));
				repeat ($urandom_range(0, 20))
					send(suis_pkg::CMD_ADD, pick_id(), LEN_W'($urandom_range(0, 16)));
			end
			2, 3: repeat ($urandom_range(1, 6))
				send(suis_pkg::CMD_ADD, pick_id(), LEN_W'($urandom_range(0, 16)));
			4, 5: stream_match(elems, elems.size());
			6: begin
				// one element differs
				if (elems.size() == 0) begin
					elems.push_back(pick_id());
				end else begin
					k = $urandom_range(0, elems.size() - 1);
					elems[k] = elems[k] ^ (ID_BITS'(1) << $urandom_range(0, ID_BITS - 1));
				end
				stream_match(elems, elems.size());
			end
			7: begin
				// one element too many or too few
				if (elems.size() < LIST_DEPTH && $urandom_range(0, 1))
					elems.push_back(pick_id());
				else if (elems.size() > 0)
					void'(elems.pop_back());
				stream_match(elems, elems.size());
			end
			8: begin
				// break off a sequence part-way
				if (elems.size() > 1) begin
					cut = $urandom_range(1, elems.size() - 1);
					for (k = 0; k < cut; k++)
						send(suis_pkg::CMD_MATCH, elems[k], LEN_W'(elems.size()));
					case ($urandom_range(0, 2))
					0: send(suis_pkg::CMD_MATCH, elems[cut], LEN_W'($urandom_range(0, cut)));
					1: send(suis_pkg::CMD_ADD, pick_id(), LEN_W'($urandom_range(0, 16)));
					default: send(suis_pkg::CMD_SET, pick_id(), LEN_W'($urandom_range(0, 16)));
					endcase
				end
			end
			default: repeat ($urandom_range(1, 4))
				send(CMD_W'($urandom_range(0, 3)), $urandom, LEN_W'($urandom_range(0, 16)));
			endcase
		end
		start <= 1'b0;

		repeat (100) begin
			if (outstanding == 0)
				break;
			@(posedge clk);
		end
		repeat (4)
			@(posedge clk);

		if (fails == 0 && outstanding == 0) begin
			$display("sorted_unique_id_set test passed");
		end else begin
			$display("sorted_unique_id_set test failed");
		end
		$finish;
	end

	initial begin
		#200us;
		$display("sorted_unique_id_set test failed");
		$finish;
	end

endmodule
